@@ rtl/core/csoc_pkg.sv @@
// Package with shared types, constants and the voltage-to-SoC table for the SoC estimator.
package csoc_pkg;

	localparam int CHARGE_BITS_DEF    = 40;
	localparam int COEF_FRAC_BITS_DEF = 16;
	localparam int CAMS_PER_MAH       = 360000;
	localparam int DIV_BITS           = 48;

	typedef enum logic [2:0] {
		REG_CAPACITY  = 3'd0,
		REG_VMIN      = 3'd1,
		REG_VMAX      = 3'd2,
		REG_INIT      = 3'd3,
		REG_REST_CUR  = 3'd4,
		REG_REST_TIME = 3'd5
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_UPDATE,
		ST_SEED_MUL,
		ST_SEED_CAP,
		ST_DIV_SOC1,
		ST_DIV_SOC2,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic                start;
		logic [DIV_BITS-1:0] dividend;
		logic [DIV_BITS-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic                busy;
		logic                done;
		logic [DIV_BITS-1:0] quotient;
	} div_rsp_t;

	// Segment bounds (exclusive upper codes) and coefficients scaled by 1e5.
	function automatic logic [2:0] seg_of(input logic [7:0] code);
		logic [2:0] s;
		if (code < 8'd90) s = 3'd0;
		else if (code < 8'd137) s = 3'd1;
		else if (code < 8'd150) s = 3'd2;
		else if (code < 8'd162) s = 3'd3;
		else if (code < 8'd171) s = 3'd4;
		else if (code < 8'd182) s = 3'd5;
		else if (code < 8'd190) s = 3'd6;
		else s = 3'd7;
		return s;
	endfunction

	function automatic logic [24:0] seg_a(input logic [2:0] i);
		logic [24:0] v;
		unique case (i)
			3'd0: v = 25'd4082;
			3'd1: v = 25'd33497;
			3'd2: v = 25'd132143;
			3'd3: v = 25'd183199;
			3'd4: v = 25'd89213;
			3'd5: v = 25'd131098;
			3'd6: v = 25'd100031;
			default: v = 25'd135913;
		endcase
		return v;
	endfunction

	function automatic logic [24:0] seg_b(input logic [2:0] i);
		logic [24:0] v;
		unique case (i)
			3'd0: v = 25'd265330;
			3'd1: v = 25'd2912730;
			3'd2: v = 25'd16407270;
			3'd3: v = 25'd24106610;
			3'd4: v = 25'd8861470;
			3'd5: v = 25'd16019420;
			3'd6: v = 25'd10362090;
			default: v = 25'd17168870;
		endcase
		return v;
	endfunction

endpackage

@@ rtl/core/csoc_table.sv @@
// Piecewise-linear voltage-code to SoC conversion, registered output.
module csoc_table import csoc_pkg::*; #(
	parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
	input  logic        clk,
	input  logic [7:0]  code,
	output logic [13:0] soc_s1
);
	localparam int F = COEF_FRAC_BITS;
	localparam longint ONE = 64'd1;
	// Q(F) coefficients rounded half up, computed at elaboration per segment.
	localparam int QW = 25 + F;

	function automatic logic [QW-1:0] to_q(input logic [24:0] v);
		logic [QW+16:0] x;
		x = ({{17{1'b0}}, v, {F{1'b0}}}) + (QW+17)'(50000);
		return QW'(x / (QW+17)'(100000));
	endfunction

	localparam logic [QW-1:0] QA [8] = '{to_q(seg_a(3'd0)), to_q(seg_a(3'd1)),
		to_q(seg_a(3'd2)), to_q(seg_a(3'd3)), to_q(seg_a(3'd4)), to_q(seg_a(3'd5)),
		to_q(seg_a(3'd6)), to_q(seg_a(3'd7))};
	localparam logic [QW-1:0] QB [8] = '{to_q(seg_b(3'd0)), to_q(seg_b(3'd1)),
		to_q(seg_b(3'd2)), to_q(seg_b(3'd3)), to_q(seg_b(3'd4)), to_q(seg_b(3'd5)),
		to_q(seg_b(3'd6)), to_q(seg_b(3'd7))};

	logic [2:0]    seg;
	logic [QW-1:0] qa;
	logic [QW-1:0] qb;
	logic signed [QW+9:0] s;
	logic [QW+9:0] sc;
	logic [QW+16:0] scaled;

	always_comb begin
		seg = seg_of(code);
		qa  = QA[seg];
		qb  = QB[seg];
		s   = $signed({10'd0, qa}) * $signed({{(QW+2){1'b0}}, code}) - $signed({10'd0, qb});
		if (s < 0) sc = '0;
		else if (s > $signed((QW+10)'(100 * (ONE << F)))) sc = (QW+10)'(100 * (ONE << F));
		else sc = s;
		scaled = (QW+17)'(sc) * (QW+17)'(100) + (QW+17)'(ONE << (F-1));
	end

	always_ff @(posedge clk) begin
		if (code < 8'd65) soc_s1 <= '0;
		else if (code >= 8'd210) soc_s1 <= 14'd10000;
		else soc_s1 <= 14'(scaled >> F);
	end
endmodule

@@ rtl/core/csoc_div.sv @@
// Restoring radix-2 divider, one quotient bit per cycle.
module csoc_div import csoc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);
	logic [DIV_BITS-1:0] rem_q, quo_q, dvs_q;
	logic [5:0]          cnt_q;
	logic                busy_q, done_q;
	logic [DIV_BITS:0]   trial;

	assign trial = {rem_q, quo_q[DIV_BITS-1]} - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'(DIV_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			if (!trial[DIV_BITS]) begin
				rem_q <= trial[DIV_BITS-1:0];
				quo_q <= {quo_q[DIV_BITS-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[DIV_BITS-2:0], quo_q[DIV_BITS-1]};
				quo_q <= {quo_q[DIV_BITS-2:0], 1'b0};
			end
		end
	end

	assign rsp.busy     = busy_q;
	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;
endmodule

@@ rtl/core/coulomb_soc_estimator_unit.sv @@
// Top level of the coulomb-counting SoC estimator with voltage recalibration.
// A sample transfer passes through three sequencer steps for the counting update
// and the table seed, two passes of a shared 48-bit bit-serial divider for the two
// SoC figures, and one step that registers the result. The two mAh figures come
// from a reciprocal multiplication while the first division runs. The block accepts
// no sample until the previous result has been taken.
module coulomb_soc_estimator_unit import csoc_pkg::*; #(
	parameter int CHARGE_BITS    = CHARGE_BITS_DEF,
	parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [7:0] cell_min_voltage, [24:8] pack_current, [40:25] elapsed_ms
	input  logic [47:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [13:0] soc_counted, [27:14] soc_recalibrated, [43:28] charge_counted_mah,
	// [59:44] charge_recal_mah, [60] is_initialized, [61] sample_accepted
	output logic [63:0] m_axis_tdata,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	localparam int CB = CHARGE_BITS;
	localparam logic [CB-1:0] CMAX = {CB{1'b1}};
	// ceil(2^42 / 5625); 360000 = 64 * 5625.
	localparam logic [29:0] MAH_RECIP = 30'd781874936;

	logic [15:0] cap_q;
	logic [7:0]  vmin_q, vmax_q, init_q;
	logic [15:0] rcur_q;
	logic [31:0] rtime_q;

	logic [CB-1:0] chg1_q, chg2_q;
	logic [31:0]   rest_q;
	logic          rdy_q;
	logic [7:0]    vcnt_q;
	logic [7:0]    lastv_q;

	state_t st_q, st_d;
	logic [7:0]  code_q;
	logic signed [16:0] cur_q;
	logic [15:0] ms_q;
	logic        ok_q;
	logic [13:0] soc1_q, soc2_q;
	logic [15:0] mah1_q, mah2_q;
	logic [63:0] out_q;
	logic        ovalid_q;
	logic        recal_q;
	logic        seeding_q;
	logic [47:0] seed_q;

	logic [7:0]     tcode;
	logic [13:0]    tsoc;
	logic [CB-1:0]  seed_c;
	div_req_t       dreq;
	div_rsp_t       drsp;
	logic [15:0]    capn;
	logic [38:0]    capc;
	logic signed [33:0] dlt;
	logic signed [49:0] n1, n2;
	logic [CB-1:0]  c1n, c2n;
	logic [31:0]    rest_n;
	logic [32:0]    rsum;
	logic           inband;

	// The table follows the sample's own code when it is accepted.
	assign tcode = ok_q ? code_q : lastv_q;

	csoc_table #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_tab (
		.clk(clk), .code(tcode), .soc_s1(tsoc));
	csoc_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	assign capn = (cap_q == 16'd0) ? 16'd1 : cap_q;
	assign capc = 39'(capn) * 39'(CAMS_PER_MAH);
	assign seed_c = (seed_q > 48'(CMAX)) ? CMAX : CB'(seed_q);
	assign cfg_ready = (st_q == ST_IDLE);
	assign s_axis_tready = (st_q == ST_IDLE) && !ovalid_q;
	assign m_axis_tvalid = ovalid_q;
	assign m_axis_tdata  = out_q;

	function automatic logic [CB-1:0] clampc(input logic signed [49:0] v,
			input logic [38:0] c);
		logic [49:0] r;
		if (v < 0) r = '0;
		else if (v > $signed({11'd0, c})) r = {11'd0, c};
		else r = v;
		if (r > 50'(CMAX)) r = 50'(CMAX);
		return CB'(r);
	endfunction

	// Rounded charge in mAh: drop the factor 64 by a shift, then divide by 5625
	// with an exact reciprocal product; anything from 65536 mAh up saturates.
	function automatic logic [15:0] mah_of(input logic [CB-1:0] q);
		logic [CB:0]   x;
		logic [28:0]   y;
		logic [58:0]   p;
		logic [15:0]   m;
		x = {1'b0, q} + (CB+1)'(CAMS_PER_MAH / 2);
		y = 29'(x >> 6);
		p = 59'(y) * 59'(MAH_RECIP);
		if (x >= (CB+1)'(64'd65536 * 64'(CAMS_PER_MAH))) m = 16'hFFFF;
		else m = 16'(p >> 42);
		return m;
	endfunction

	always_comb begin
		dlt    = cur_q * $signed({1'b0, ms_q});
		n1     = $signed(50'(chg1_q)) + 50'(dlt);
		n2     = $signed(50'(chg2_q)) + 50'(dlt);
		c1n    = clampc(n1, capc);
		c2n    = clampc(n2, capc);
		inband = ($signed({cur_q[16], cur_q}) > -$signed({2'b0, rcur_q})) &&
			($signed({cur_q[16], cur_q}) < $signed({2'b0, rcur_q}));
		rsum   = 33'(rest_q) + 33'(ms_q);
		rest_n = inband ? (rsum[32] ? 32'hFFFF_FFFF : rsum[31:0]) : 32'd0;
	end

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			ST_IDLE:     if (s_axis_tvalid && s_axis_tready) st_d = ST_UPDATE;
			ST_UPDATE:   st_d = ST_SEED_MUL;
			ST_SEED_MUL: st_d = ST_SEED_CAP;
			ST_SEED_CAP: st_d = ST_DIV_SOC1;
			ST_DIV_SOC1: if (drsp.done) st_d = ST_DIV_SOC2;
			ST_DIV_SOC2: if (drsp.done) st_d = ST_DONE;
			ST_DONE:     st_d = ST_IDLE;
			default:     st_d = ST_IDLE;
		endcase
	end

	// Each divider pass is started on entry to its state.
	always_comb begin
		dreq.start    = 1'b0;
		dreq.dividend = '0;
		dreq.divisor  = 48'(capc);
		unique case (st_q)
			ST_SEED_CAP: begin
				// Estimate 1 is seeded at the end of this state, so its new value is
				// taken straight from the seed.
				dreq.start    = 1'b1;
				dreq.dividend = 48'(seeding_q ? seed_c : chg1_q) * 48'd10000 +
					48'(capc >> 1);
			end
			ST_DIV_SOC1: begin
				dreq.start    = drsp.done;
				dreq.dividend = 48'(chg2_q) * 48'd10000 + 48'(capc >> 1);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= ST_IDLE;
			ovalid_q <= 1'b0;
			cap_q    <= 16'd50000;
			vmin_q   <= 8'd0;
			vmax_q   <= 8'd255;
			init_q   <= 8'd10;
			rcur_q   <= 16'd100;
			rtime_q  <= 32'd60000;
			chg1_q   <= CB'(64'd50000 * 64'(CAMS_PER_MAH));
			chg2_q   <= CB'(64'd50000 * 64'(CAMS_PER_MAH));
			rest_q   <= '0;
			rdy_q    <= 1'b0;
			vcnt_q   <= '0;
			lastv_q  <= 8'd66;
			recal_q  <= 1'b0;
		end else begin
			st_q <= st_d;
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_CAPACITY:  cap_q   <= cfg_data[15:0];
					REG_VMIN:      vmin_q  <= cfg_data[7:0];
					REG_VMAX:      vmax_q  <= cfg_data[7:0];
					REG_INIT:      init_q  <= cfg_data[7:0];
					REG_REST_CUR:  rcur_q  <= cfg_data[15:0];
					REG_REST_TIME: rtime_q <= cfg_data;
					default: ;
				endcase
			end
			if (st_q == ST_DONE) ovalid_q <= 1'b1;
			else if (m_axis_tready && ovalid_q) ovalid_q <= 1'b0;
			unique case (st_q)
				ST_UPDATE: begin
					recal_q <= 1'b0;
					if (ok_q) begin
						lastv_q <= code_q;
						if (!rdy_q) begin
							if (vcnt_q != 8'hFF) vcnt_q <= vcnt_q + 8'd1;
							if (((vcnt_q == 8'hFF) ? vcnt_q : vcnt_q + 8'd1) >= init_q) begin
								rdy_q   <= 1'b1;
								recal_q <= 1'b1;
							end
						end else begin
							chg1_q <= c1n;
							rest_q <= rest_n;
							if (rest_n > rtime_q) recal_q <= 1'b1;
							else chg2_q <= c2n;
						end
					end
				end
				ST_SEED_CAP: begin
					// The seed was formed in ST_SEED_MUL from the table output.
					if (recal_q) begin
						chg2_q <= seed_c;
						if (seeding_q) chg1_q <= seed_c;
					end
				end
				default: ;
			endcase
		end
	end

	// On a seeding sample estimate 1 is seeded too; recal alone touches estimate 2.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) seeding_q <= 1'b0;
		else if (st_q == ST_UPDATE) seeding_q <= ok_q && !rdy_q;
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			code_q <= s_axis_tdata[7:0];
			cur_q  <= $signed(s_axis_tdata[24:8]);
			ms_q   <= s_axis_tdata[40:25];
			ok_q   <= (s_axis_tdata[7:0] >= vmin_q) && (s_axis_tdata[7:0] <= vmax_q);
		end
		if (st_q == ST_SEED_MUL) seed_q <= 48'(tsoc) * 48'(capn) * 48'd36;
		if (st_q == ST_DIV_SOC1) begin
			mah1_q <= mah_of(chg1_q);
			mah2_q <= mah_of(chg2_q);
		end
		if (drsp.done) begin
			unique case (st_q)
				ST_DIV_SOC1: soc1_q <= (drsp.quotient > 48'd10000) ? 14'd10000 : 14'(drsp.quotient);
				ST_DIV_SOC2: soc2_q <= (drsp.quotient > 48'd10000) ? 14'd10000 : 14'(drsp.quotient);
				default: ;
			endcase
		end
		if (st_q == ST_DONE)
			out_q <= {2'b00, ok_q, rdy_q, mah2_q, mah1_q,
				rdy_q ? soc2_q : 14'd0, rdy_q ? soc1_q : 14'd0};
	end
endmodule

@@ rtl/core/csoc_checker.sv @@
// Port-level checker for the SoC estimator, bound to the top level.
module csoc_assertions (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [63:0] m_axis_tdata
);
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !s_axis_tready) else $error("input taken with result pending");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");
	a_soc_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[13:0] <= 14'd10000 && m_axis_tdata[27:14] <= 14'd10000)
		else $error("SoC out of range");
	a_soc_zero_uninit: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tdata[60] |-> m_axis_tdata[27:0] == 28'd0)
		else $error("SoC nonzero before init");
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("ready right after transfer");
endmodule

bind coulomb_soc_estimator_unit csoc_assertions u_csoc_assertions (
	.clk(clk), .arst_n(arst_n), .s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata));
